/* rtl/tpc_pkg.sv */
// shared constants for the triangle point containment test core
// no dependencies; used by the core, the port checker and the testbench
`default_nettype none

package tpc_pkg;

  // default sizes of the point store and of one coordinate
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  // stream layout: six 16-bit coordinate fields in tdata, operation in tuser
  localparam int FIELD_BITS     = 16;
  localparam int NUM_FIELDS     = 6;
  localparam int IN_TDATA_BITS  = FIELD_BITS * NUM_FIELDS;
  localparam int OUT_TDATA_BITS = 8;

  // field slots inside the input tdata
  localparam int F_AX = 0;
  localparam int F_AY = 1;
  localparam int F_BX = 2;
  localparam int F_BY = 3;
  localparam int F_CX = 4;
  localparam int F_CY = 5;

  // operation codes carried in tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

/* rtl/tpc_point_eval.sv */
// per-point evaluator: sum of the three doubled sub-areas against the whole area
// depends on nothing but its parameter; instantiated by the core
`default_nettype none

module tpc_point_eval #(
  parameter int COORD_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // stored point, one per cycle
  input  wire                                   pt_valid,
  input  wire  signed [COORD_BITS-1:0]          pt_x,
  input  wire  signed [COORD_BITS-1:0]          pt_y,
  // sub-area k = px*d[k] + py*e[k] + c[k], held for the whole scan
  input  wire         [2:0][COORD_BITS:0]       coef_d,
  input  wire         [2:0][COORD_BITS:0]       coef_e,
  input  wire         [2:0][2*COORD_BITS:0]     coef_c,
  input  wire         [2*COORD_BITS+5:0]        whole_area,
  output logic                                  hit_valid,
  output logic                                  hit,
  output logic                                  busy
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int KW = 2 * COORD_BITS + 1;
  localparam int AW = 2 * COORD_BITS + 6;

  logic                 v1_r, v2_r, v3_r;
  logic signed [PW-1:0] mx_r [3];
  logic signed [PW-1:0] my_r [3];
  logic        [AW-1:0] ab_r [3];
  logic signed [AW-1:0] sa   [3];
  logic        [AW-1:0] tot;
  logic                 hit_r;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= pt_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: six products of the point with the edge differences
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mx_r[k] <= PW'(pt_x) * PW'($signed(coef_d[k][DW-1:0]));
      my_r[k] <= PW'(pt_y) * PW'($signed(coef_e[k][DW-1:0]));
    end
  end

  // stage 2: signed sub-area and its magnitude
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sa[k] = AW'(mx_r[k]) + AW'(my_r[k]) + AW'($signed(coef_c[k][KW-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ab_r[k] <= sa[k][AW-1] ? AW'(-sa[k]) : AW'(sa[k]);
    end
  end

  // stage 3: compare the sum against the whole area
  assign tot = ab_r[0] + ab_r[1] + ab_r[2];

  always_ff @(posedge clk) begin
    hit_r <= (tot == whole_area);
  end

  assign hit_valid = v3_r;
  assign hit       = hit_r;
  assign busy      = v1_r | v2_r | v3_r;

endmodule

`default_nettype wire

/* rtl/triangle_point_containment_test_core.sv */
// top level of the triangle point containment test core
// depends on tpc_pkg and tpc_point_eval
`default_nettype none

// A load transfer (tuser = load) writes corner a into the next free entry of
// the point store; loads beyond MAX_POINTS are dropped and give no result. A
// query transfer forms the whole doubled area and the per-edge coefficients
// in the states PROD, KSUM and WHOLE, then reads one stored point per cycle
// from the point memory, then drains the evaluator. One query is in flight
// at a time; the result register lets the next item be accepted while a
// result waits.

module triangle_point_containment_test_core #(
  parameter int MAX_POINTS = tpc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = tpc_pkg::COORD_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // input stream
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, 16 bits each from bit 0
  input  wire  [tpc_pkg::IN_TDATA_BITS-1:0]    in_tdata,
  // operation
  input  wire  [0:0]                           in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // is_empty, then zero fill
  output logic [tpc_pkg::OUT_TDATA_BITS-1:0]   out_tdata
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int QW   = 2 * CW;
  localparam int KW   = 2 * CW + 1;
  localparam int AW   = 2 * CW + 6;
  localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int EXTW = (CW > tpc_pkg::FIELD_BITS) ? CW : tpc_pkg::FIELD_BITS;
  localparam int NF   = tpc_pkg::NUM_FIELDS;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PROD  = 7'b0000010,
    ST_KSUM  = 7'b0000100,
    ST_WHOLE = 7'b0001000,
    ST_SCAN  = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNTW-1:0]       cnt_r;
  logic [CNTW-1:0]       idx_r, idx_nxt;
  logic                  rd_valid_r, rd_valid_nxt;
  logic                  hit_acc_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_empty_r, out_empty_nxt;

  logic [EXTW-1:0]       fld_ext [NF];
  logic signed [CW-1:0]  crd_in  [NF];
  logic signed [CW-1:0]  crd_r   [NF];

  logic [2:0][DW-1:0]    d_r, e_r;
  logic signed [QW-1:0]  q_r [6];
  logic [2:0][KW-1:0]    k_r;
  logic signed [AW-1:0]  whole_s;
  logic [AW-1:0]         whole_r;

  logic [2*CW-1:0]       mem [MAX_POINTS];
  logic [2*CW-1:0]       mem_q;

  logic                  in_xfer, load_xfer, query_xfer;
  logic                  hit_valid, hit, eval_busy;

  // coordinate fields: low COORD_BITS of each field, two's complement
  for (genvar g = 0; g < NF; g++) begin : g_fld
    assign fld_ext[g] = EXTW'(in_tdata[g*tpc_pkg::FIELD_BITS +: tpc_pkg::FIELD_BITS]);
    assign crd_in[g]  = $signed(fld_ext[g][CW-1:0]);
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid & in_tready;
  assign load_xfer  = in_xfer & (in_tuser[0] == tpc_pkg::OP_LOAD);
  assign query_xfer = in_xfer & (in_tuser[0] == tpc_pkg::OP_QUERY);

  // point memory: write on load, one registered read per cycle
  always_ff @(posedge clk) begin
    if (load_xfer && (cnt_r < CNTW'(MAX_POINTS))) begin
      mem[cnt_r[IW-1:0]] <= {crd_in[tpc_pkg::F_AY], crd_in[tpc_pkg::F_AX]};
    end
    mem_q <= mem[idx_r[IW-1:0]];
  end

  // point count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load_xfer && (cnt_r < CNTW'(MAX_POINTS))) begin
      cnt_r <= cnt_r + CNTW'(1);
    end
  end

  // query corners held for the whole query
  always_ff @(posedge clk) begin
    if (query_xfer) begin
      for (int f = 0; f < NF; f++) begin
        crd_r[f] <= crd_in[f];
      end
    end
  end

  // edge differences and corner cross products
  always_ff @(posedge clk) begin
    d_r[0] <= DW'(crd_r[tpc_pkg::F_BY]) - DW'(crd_r[tpc_pkg::F_CY]);
    e_r[0] <= DW'(crd_r[tpc_pkg::F_CX]) - DW'(crd_r[tpc_pkg::F_BX]);
    d_r[1] <= DW'(crd_r[tpc_pkg::F_CY]) - DW'(crd_r[tpc_pkg::F_AY]);
    e_r[1] <= DW'(crd_r[tpc_pkg::F_AX]) - DW'(crd_r[tpc_pkg::F_CX]);
    d_r[2] <= DW'(crd_r[tpc_pkg::F_AY]) - DW'(crd_r[tpc_pkg::F_BY]);
    e_r[2] <= DW'(crd_r[tpc_pkg::F_BX]) - DW'(crd_r[tpc_pkg::F_AX]);
    q_r[0] <= QW'(crd_r[tpc_pkg::F_BX]) * QW'(crd_r[tpc_pkg::F_CY]);
    q_r[1] <= QW'(crd_r[tpc_pkg::F_CX]) * QW'(crd_r[tpc_pkg::F_BY]);
    q_r[2] <= QW'(crd_r[tpc_pkg::F_CX]) * QW'(crd_r[tpc_pkg::F_AY]);
    q_r[3] <= QW'(crd_r[tpc_pkg::F_AX]) * QW'(crd_r[tpc_pkg::F_CY]);
    q_r[4] <= QW'(crd_r[tpc_pkg::F_AX]) * QW'(crd_r[tpc_pkg::F_BY]);
    q_r[5] <= QW'(crd_r[tpc_pkg::F_BX]) * QW'(crd_r[tpc_pkg::F_AY]);
  end

  // constant terms of the three sub-areas
  always_ff @(posedge clk) begin
    k_r[0] <= KW'(q_r[0]) - KW'(q_r[1]);
    k_r[1] <= KW'(q_r[2]) - KW'(q_r[3]);
    k_r[2] <= KW'(q_r[4]) - KW'(q_r[5]);
  end

  // whole doubled area: magnitude of the sum of the constant terms
  assign whole_s = AW'($signed(k_r[0])) + AW'($signed(k_r[1])) + AW'($signed(k_r[2]));

  always_ff @(posedge clk) begin
    whole_r <= whole_s[AW-1] ? AW'(-whole_s) : AW'(whole_s);
  end

  tpc_point_eval #(
    .COORD_BITS (COORD_BITS)
  ) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .pt_valid   (rd_valid_r),
    .pt_x       ($signed(mem_q[CW-1:0])),
    .pt_y       ($signed(mem_q[2*CW-1:CW])),
    .coef_d     (d_r),
    .coef_e     (e_r),
    .coef_c     (k_r),
    .whole_area (whole_r),
    .hit_valid  (hit_valid),
    .hit        (hit),
    .busy       (eval_busy)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rd_valid_nxt  = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_empty_nxt = out_empty_r;
    case (state_r)
      ST_IDLE: begin
        if (query_xfer) begin
          state_nxt = ST_PROD;
          idx_nxt   = '0;
        end
      end
      ST_PROD: begin
        state_nxt = ST_KSUM;
      end
      ST_KSUM: begin
        state_nxt = ST_WHOLE;
      end
      ST_WHOLE: begin
        state_nxt = (cnt_r == '0) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        rd_valid_nxt = 1'b1;
        idx_nxt      = idx_r + CNTW'(1);
        if (idx_r + CNTW'(1) == cnt_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid_r && !eval_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_empty_nxt = ~hit_acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hit_acc_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // any point inside or on the triangle marks it occupied
      if (query_xfer) begin
        hit_acc_r <= 1'b0;
      end else if (hit_valid && hit) begin
        hit_acc_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tpc_pkg::OUT_TDATA_BITS-1){1'b0}}, out_empty_r};

endmodule

`default_nettype wire

/* rtl/tpc_checker.sv */
// port-level checker for the triangle point containment test core
// depends on tpc_pkg; bound to the core at the end of this file
`default_nettype none

module tpc_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_tvalid,
  input wire                                 in_tready,
  input wire [0:0]                           in_tuser,
  input wire                                 out_tvalid,
  input wire                                 out_tready,
  input wire [tpc_pkg::OUT_TDATA_BITS-1:0]   out_tdata
);

  logic in_xfer;
  logic in_load;
  logic in_query;

  assign in_xfer  = in_tvalid & in_tready;
  assign in_load  = in_xfer & (in_tuser[0] == tpc_pkg::OP_LOAD);
  assign in_query = in_xfer & (in_tuser[0] == tpc_pkg::OP_QUERY);

  // a waiting result holds until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_load && !out_tvalid |=> !out_tvalid)
    else $error("result appeared after a load");

  // a query does not return its result right away
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_query && !out_tvalid |=> !out_tvalid ##1 !out_tvalid)
    else $error("result appeared too early after a query");

  // one query at a time: input stalls right after a query
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_query |=> !in_tready)
    else $error("input accepted while a query is running");

  // zero fill above the result bit
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[tpc_pkg::OUT_TDATA_BITS-1:1] == '0)
    else $error("nonzero fill bits in result");

endmodule

bind triangle_point_containment_test_core tpc_checker u_tpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* test/triangle_point_containment_test_core_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for triangle_point_containment_test_core
// predicts each query answer from its own copy of the obstacle store
// depends on tpc_pkg and the core; drives the input stream and checks the result stream

module triangle_point_containment_test_core_test;

  localparam int MAX_PTS        = tpc_pkg::MAX_POINTS_DEF;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int DRAIN_EVERY    = 400;
  localparam int HOLD_CYCLES    = 600;
  localparam int HOLD_AFTER     = 150;
  localparam int TAIL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int FB             = tpc_pkg::FIELD_BITS;

  typedef logic signed [tpc_pkg::FIELD_BITS-1:0] coord_t;

  typedef struct {
    logic   op;
    coord_t ax, ay, bx, by, cx, cy;
    bit     wait_drain;
  } tri_item_t;

  // triangle shapes used by the random queries
  typedef enum int {
    SH_RANDOM, SH_AROUND, SH_ON_EDGE, SH_VERTEX,
    SH_COLLINEAR, SH_NEAR_MISS, SH_SMALL, SH_EXTREME
  } shape_t;

  // receiver stall patterns
  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                               clk;
  logic                               rst_n;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [tpc_pkg::IN_TDATA_BITS-1:0]  in_tdata;
  logic [0:0]                         in_tuser;
  logic                               out_tvalid;
  logic                               out_tready;
  logic [tpc_pkg::OUT_TDATA_BITS-1:0] out_tdata;

  triangle_point_containment_test_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // pending stimulus and the answers still owed by the block
  tri_item_t pending_q[$];
  bit        empty_flag_q[$];

  // predicted obstacle store
  coord_t obst_x[MAX_PTS];
  coord_t obst_y[MAX_PTS];
  int     obst_count;

  // generator-side view of what has been loaded
  int  gen_x[$];
  int  gen_y[$];
  bit  drain_next;

  // run bookkeeping
  bit  in_taken;
  bit  offer_active;
  bit  timed_out;
  int  idle_cycles;
  int  fail_count;
  int  results_seen;
  int  empty_answers;
  int  loads_kept;
  int  loads_dropped;
  int  queries_sent;

  tri_item_t cur_item;

  function automatic longint doubled_area(longint px, longint py, longint qx, longint qy,
                                          longint rx, longint ry);
    longint s;
    s = px * (qy - ry) + qx * (ry - py) + rx * (py - qy);
    return (s < 0) ? -s : s;
  endfunction

  // a point is inside or on the edge when its three sub-areas add up to the whole
  function automatic bit predict_empty(tri_item_t it);
    longint ax, ay, bx, by, cx, cy, px, py, whole, sum;
    bit     found;
    int     i;
    ax = it.ax; ay = it.ay;
    bx = it.bx; by = it.by;
    cx = it.cx; cy = it.cy;
    found = 1'b0;
    whole = doubled_area(ax, ay, bx, by, cx, cy);
    for (i = 0; i < obst_count && !found; i++) begin
      px  = obst_x[i];
      py  = obst_y[i];
      sum = doubled_area(px, py, bx, by, cx, cy) + doubled_area(ax, ay, px, py, cx, cy)
          + doubled_area(ax, ay, bx, by, px, py);
      if (sum == whole) found = 1'b1;
    end
    return !found;
  endfunction

  // update the predicted state for one accepted transfer
  task automatic apply_item(tri_item_t it);
    if (it.op == tpc_pkg::OP_LOAD) begin
      if (obst_count < MAX_PTS) begin
        obst_x[obst_count] = it.ax;
        obst_y[obst_count] = it.ay;
        obst_count++;
        loads_kept++;
      end else begin
        loads_dropped++;
      end
    end else begin
      empty_flag_q.insert(empty_flag_q.size(), predict_empty(it));
      queries_sent++;
    end
  endtask

  task automatic push_load(int x, int y, int junk_b, int junk_c);
    tri_item_t it;
    it.op = tpc_pkg::OP_LOAD;
    it.ax = x[15:0];      it.ay = y[15:0];
    it.bx = junk_b[15:0]; it.by = junk_c[15:0];
    it.cx = junk_c[15:0]; it.cy = junk_b[15:0];
    it.wait_drain = drain_next;
    drain_next = 1'b0;
    pending_q.insert(pending_q.size(), it);
    if (gen_x.size() < MAX_PTS) begin
      gen_x.insert(gen_x.size(), int'(coord_t'(x[15:0])));
      gen_y.insert(gen_y.size(), int'(coord_t'(y[15:0])));
    end
  endtask

  task automatic push_query(int ax, int ay, int bx, int by, int cx, int cy);
    tri_item_t it;
    it.op = tpc_pkg::OP_QUERY;
    it.ax = ax[15:0]; it.ay = ay[15:0];
    it.bx = bx[15:0]; it.by = by[15:0];
    it.cx = cx[15:0]; it.cy = cy[15:0];
    it.wait_drain = drain_next;
    drain_next = 1'b0;
    pending_q.insert(pending_q.size(), it);
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int offset(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 2))
      0:       return -32768;
      1:       return 32767;
      default: return rand_coord();
    endcase
  endfunction

  // one random query; most shapes are placed around a stored point
  task automatic gen_query();
    int     vx[3], vy[3];
    int     px, py, dx, dy, k, m, r, rot, idx;
    shape_t shape;
    idx   = $urandom_range(0, gen_x.size() - 1);
    px    = gen_x[idx];
    py    = gen_y[idx];
    shape = shape_t'($urandom_range(0, 7));
    case (shape)
      SH_AROUND: begin
        r = 1 << $urandom_range(0, 12);
        vx[0] = px - int'($urandom_range(0, r)); vy[0] = py - int'($urandom_range(0, r));
        vx[1] = px + int'($urandom_range(0, r)); vy[1] = py - int'($urandom_range(0, r));
        vx[2] = px + offset(r);                  vy[2] = py + int'($urandom_range(0, r));
      end
      SH_ON_EDGE, SH_NEAR_MISS: begin
        // point on segment a-b; the near miss shifts it by one unit
        if (shape == SH_NEAR_MISS) begin
          if ($urandom_range(0, 1)) px += ($urandom_range(0, 1) ? 1 : -1);
          else                      py += ($urandom_range(0, 1) ? 1 : -1);
        end
        dx = offset(8); dy = offset(8);
        k  = $urandom_range(0, 6); m = $urandom_range(0, 6);
        vx[0] = px - k * dx;       vy[0] = py - k * dy;
        vx[1] = px + m * dx;       vy[1] = py + m * dy;
        vx[2] = px + offset(300);  vy[2] = py + offset(300);
      end
      SH_VERTEX: begin
        r = 1 << $urandom_range(0, 15);
        vx[0] = px;             vy[0] = py;
        vx[1] = px + offset(r); vy[1] = py + offset(r);
        vx[2] = px + offset(r); vy[2] = py + offset(r);
      end
      SH_COLLINEAR: begin
        dx = offset(10); dy = offset(10);
        k = offset(5); vx[0] = px + k * dx; vy[0] = py + k * dy;
        k = offset(5); vx[1] = px + k * dx; vy[1] = py + k * dy;
        k = offset(5); vx[2] = px + k * dx; vy[2] = py + k * dy;
      end
      SH_SMALL: begin
        px = rand_coord(); py = rand_coord();
        vx[0] = px;              vy[0] = py;
        vx[1] = px + offset(64); vy[1] = py + offset(64);
        vx[2] = px + offset(64); vy[2] = py + offset(64);
      end
      SH_EXTREME: begin
        vx[0] = extreme_coord(); vy[0] = extreme_coord();
        vx[1] = extreme_coord(); vy[1] = extreme_coord();
        vx[2] = extreme_coord(); vy[2] = extreme_coord();
      end
      default: begin
        vx[0] = rand_coord(); vy[0] = rand_coord();
        vx[1] = rand_coord(); vy[1] = rand_coord();
        vx[2] = rand_coord(); vy[2] = rand_coord();
      end
    endcase
    // rotate corners and pick the winding at random
    rot = $urandom_range(0, 2);
    if ($urandom_range(0, 1))
      push_query(vx[rot], vy[rot], vx[(rot + 1) % 3], vy[(rot + 1) % 3],
                 vx[(rot + 2) % 3], vy[(rot + 2) % 3]);
    else
      push_query(vx[rot], vy[rot], vx[(rot + 2) % 3], vy[(rot + 2) % 3],
                 vx[(rot + 1) % 3], vy[(rot + 1) % 3]);
  endtask

  // driver: offers pending items in bursts, predicts each accepted transfer
  int burst_left;
  int gap_left;

  always @(negedge clk) begin : driver
    bit                                drive_valid;
    logic [tpc_pkg::IN_TDATA_BITS-1:0] drive_data;
    drive_valid = 1'b0;
    drive_data  = '0;
    if (rst_n) begin
      if (in_taken && offer_active) begin
        apply_item(cur_item);
        offer_active = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 :
                       (($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12));
        end
      end
      if (!offer_active) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          // a marked item waits until every owed answer is back
          if (!pending_q[0].wait_drain || empty_flag_q.size() == 0) begin
            cur_item     = pending_q.pop_front();
            offer_active = 1'b1;
            drive_data[tpc_pkg::F_AX*FB +: FB] = cur_item.ax;
            drive_data[tpc_pkg::F_AY*FB +: FB] = cur_item.ay;
            drive_data[tpc_pkg::F_BX*FB +: FB] = cur_item.bx;
            drive_data[tpc_pkg::F_BY*FB +: FB] = cur_item.by;
            drive_data[tpc_pkg::F_CX*FB +: FB] = cur_item.cx;
            drive_data[tpc_pkg::F_CY*FB +: FB] = cur_item.cy;
            in_tdata <= drive_data;
            in_tuser <= cur_item.op;
          end
        end
      end
      drive_valid = offer_active;
    end
    in_tvalid <= drive_valid;
  end

  // receiver: changing stall patterns plus one long hold-off
  rx_mode_t rx_mode;
  int       rx_phase_left;
  int       rx_tick;
  int       hold_left;
  bit       hold_done;

  always @(negedge clk) begin : receiver
    bit ready;
    ready = 1'b0;
    if (rst_n) begin
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
      end else begin
        if (rx_phase_left == 0) begin
          rx_mode       = rx_mode_t'($urandom_range(0, 3));
          rx_phase_left = $urandom_range(20, 200);
        end
        rx_phase_left--;
        case (rx_mode)
          RX_FREE:     ready = 1'b1;
          RX_COIN:     ready = ($urandom_range(0, 1) == 1);
          RX_SPARSE:   ready = ($urandom_range(0, 3) == 0);
          RX_PERIODIC: ready = (rx_tick % 5) != 0;
          default:     ready = 1'b1;
        endcase
      end
    end
    out_tready <= ready;
  end

  // monitor: checks each result transfer against the oldest owed answer
  always @(posedge clk) begin : monitor
    bit                                 exp_empty;
    logic [tpc_pkg::OUT_TDATA_BITS-1:0] exp_data;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (empty_flag_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d with no answer owed: tdata %02h", results_seen, out_tdata);
        end else begin
          exp_empty = empty_flag_q.pop_front();
          exp_data  = '0;
          exp_data[0] = exp_empty;
          if (exp_empty) empty_answers++;
          if (out_tdata !== exp_data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d mismatch: expected tdata %02h (is_empty %0d), got %02h",
                       results_seen, exp_data, exp_empty, out_tdata);
          end
        end
      end
      // watchdog on cycles without any transfer
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
      end
    end
  end

  initial begin : main
    int counted;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    burst_left = $urandom_range(1, 40);

    // directed: empty store, extreme points, edges, vertices, degenerate shapes
    push_query(-32768, -32768, 32767, -32768, 0, 32767);
    push_load(-32768, -32768, 16'hFFFF, 16'hFFFF);
    push_load(32767, 32767, 0, 0);
    push_load(0, 0, rand_coord(), rand_coord());
    push_load(-32768, 32767, 16'h5555, 16'hAAAA);
    push_query(-32768, -32768, 32767, -32768, 32767, 32767);
    push_query(100, 100, 110, 100, 100, 110);
    push_query(-10, -10, 10, 10, 10, -20);
    push_query(-5, -5, 5, 5, 2, 2);
    push_query(1, 0, 3, 0, 5, 0);
    push_query(7, 7, 7, 7, 7, 7);
    push_query(1, 1, 20, 1, 1, 20);
    push_query(32767, 32767, 32766, 32767, 32767, 32766);
    push_query(32767, 32767, 32767, 32766, 32766, 32767);
    push_query(-32768, 32767, 32767, -32768, 32767, 32767);
    push_query(21845, -21846, -21846, 21845, 21845, 21845);
    push_query(-1, -1, 1, -1, 0, 1);

    // random: fill the store gradually, then keep querying; loads past full are dropped
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % DRAIN_EVERY == 0) drain_next = 1'b1;
      if (gen_x.size() < MAX_PTS && $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 9) < 7)
          push_load(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        else
          push_load(offset(200), offset(200), rand_coord(), rand_coord());
        counted++;
      end else if (gen_x.size() >= MAX_PTS && $urandom_range(0, 15) == 0) begin
        push_load(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end else begin
        gen_query();
        counted++;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(pending_q.size() == 0 && !offer_active && empty_flag_q.size() == 0)
           && !timed_out)
      @(posedge clk);

    if (timed_out) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("triangle_point_containment_test_core test failed");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      $display("covered %0d queries (%0d answered empty) and %0d loads",
               queries_sent, empty_answers, loads_kept + loads_dropped);
      $display("%0d loads dropped on a full store, %0d results checked, %0d failures",
               loads_dropped, results_seen, fail_count);
      if (fail_count == 0 && empty_flag_q.size() == 0)
        $display("triangle_point_containment_test_core test passed");
      else
        $display("triangle_point_containment_test_core test failed");
      $finish;
    end
  end

endmodule

/* triangle_point_containment_test_core.f */
rtl/tpc_pkg.sv
rtl/tpc_point_eval.sv
rtl/triangle_point_containment_test_core.sv
rtl/tpc_checker.sv
test/triangle_point_containment_test_core_test.sv
